// ----- rtl/lsrc_pkg.sv -----
// Shared types, codes and constants of the lidar ray cell generator.
package lsrc_pkg;

  // Number of entries in the arctangent table and the width of an index into it.
  localparam int AtanLen = 24;
  localparam int IDX_W   = 5;

  // Widths of the rotation datapath.
  localparam int ROT_W   = 34;
  localparam int PROD_W  = 54;

  // CORDIC start value, 0.60725 in Q30.
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent of 2^-i as a 32-bit binary angle.
  localparam logic [31:0] ATAN_TAB [AtanLen] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_START_ANGLE  = 3'd2,
    CFG_ANGLE_STEP   = 3'd3,
    CFG_MAX_RANGE    = 3'd4,
    CFG_STEP_LENGTH  = 3'd5,
    CFG_CLEAR_RADIUS = 3'd6,
    CFG_CLEAR_ENABLE = 3'd7
  } cfg_idx_t;

  // One range sample.
  typedef struct packed {
    logic signed [23:0] range_value;
    logic               scan_start;
  } in_item_t;

  // One map cell.
  typedef struct packed {
    logic               is_occupied;
    logic signed [23:0] cell_x;
    logic signed [23:0] cell_y;
    logic [15:0]        half_extent;
    logic               last;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_MUL_X,
    S_ACC_X,
    S_MUL_Y,
    S_ACC_Y,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             rot;
    logic [IDX_W-1:0] iter;
    logic             mul;
    logic             sel_y;
    logic             acc_x;
    logic             acc_y;
    logic             emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic none;
    logic slot_free;
    logic last;
  } dp_status_t;

endpackage

// ----- rtl/lsrc_ctrl.sv -----
// Controller state machine that sequences rotation, cell products and cell transfers.
module lsrc_ctrl #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsrc_pkg::dp_status_t st,
  output lsrc_pkg::ctrl_cmd_t  cmd
);
  import lsrc_pkg::*;

  localparam int IW = (ANGLE_BITS > 1) ? $clog2(ANGLE_BITS) : 1;
  localparam logic [IW-1:0] LastIter = IW'(ANGLE_BITS - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] iter_r, iter_nxt;

  // State and iteration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    cmd.iter  = IDX_W'(iter_r);
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          iter_nxt   = '0;
          if (!st.none) begin
            state_nxt = S_ROT;
          end
        end
      end
      S_ROT: begin
        cmd.rot  = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == LastIter) begin
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC_X;
      end
      S_ACC_X: begin
        cmd.acc_x = 1'b1;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul   = 1'b1;
        cmd.sel_y = 1'b1;
        state_nxt = S_ACC_Y;
      end
      S_ACC_Y: begin
        cmd.acc_y = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.last ? S_IDLE : S_MUL_X;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The rotation always runs its full iteration count before the first product.
  a_rot_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && iter_r == LastIter) |=> state_r == S_MUL_X)
    else $error("rotation left early or late");

  // A sample that gives no cells never starts a rotation.
  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && st.none) |=> state_r == S_IDLE)
    else $error("empty sample started work");

  // A cell transfer is only issued when the output slot can take it.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.slot_free)
    else $error("cell issued into a full output slot");

endmodule

// ----- rtl/lsrc_dp.sv -----
// Datapath: configuration registers, beam angle, CORDIC, cell multiplier and output register.
module lsrc_dp #(
  parameter int MAX_STEPS = 63
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  lsrc_pkg::cfg_idx_t   cfg_index,
  input  logic [23:0]          cfg_data,
  input  lsrc_pkg::in_item_t   in_data,
  input  lsrc_pkg::ctrl_cmd_t  cmd,
  output lsrc_pkg::dp_status_t st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsrc_pkg::out_item_t  out_data
);
  import lsrc_pkg::*;

  localparam int NW = $clog2(MAX_STEPS + 1);

  // Configuration registers.
  logic signed [23:0] origin_x_r, origin_y_r;
  logic [15:0]        start_angle_r, angle_step_r, max_range_r;
  logic [15:0]        step_length_r, clear_radius_r;
  logic               clear_enable_r;
  logic [15:0]        beam_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      start_angle_r  <= '0;
      angle_step_r   <= '0;
      max_range_r    <= 16'd5120;
      step_length_r  <= 16'd102;
      clear_radius_r <= 16'd51;
      clear_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        CFG_START_ANGLE:  start_angle_r  <= cfg_data[15:0];
        CFG_ANGLE_STEP:   angle_step_r   <= cfg_data[15:0];
        CFG_MAX_RANGE:    max_range_r    <= cfg_data[15:0];
        CFG_STEP_LENGTH:  step_length_r  <= cfg_data[15:0];
        CFG_CLEAR_RADIUS: clear_radius_r <= cfg_data[15:0];
        CFG_CLEAR_ENABLE: clear_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sample classification at the input transfer.
  logic signed [23:0] max_s, range_s;
  logic signed [24:0] limit_full;
  logic               raw_occ, range_pos, free0;
  logic               none_w;
  logic [15:0]        angle_cur;

  always_comb begin
    max_s      = $signed({8'd0, max_range_r});
    raw_occ    = in_data.range_value < max_s;
    range_s    = raw_occ ? in_data.range_value : max_s;
    range_pos  = range_s > 24'sd0;
    limit_full = 25'(range_s) - $signed({9'd0, clear_radius_r});
    free0      = clear_enable_r && (limit_full > 25'sd0);
    none_w     = !range_pos || (!free0 && !raw_occ);
    angle_cur  = in_data.scan_start ? start_angle_r : beam_angle_r;
  end

  // Beam angle advances after every sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
    end else if (cmd.accept) begin
      beam_angle_r <= angle_cur + angle_step_r;
    end
  end

  // Per-sample state.
  logic [15:0]        range_r;
  logic signed [17:0] limit_r;
  logic               occ_r, phase_occ_r;
  logic [16:0]        r_cur_r;
  logic [NW-1:0]      n_r;

  // CORDIC state.
  logic signed [ROT_W-1:0] x_r, y_r, z_r;
  logic                    flip_r;
  logic [31:0]             z32;
  logic                    flip_in;
  logic signed [ROT_W-1:0] dx, dy, atan_v;

  always_comb begin
    flip_in = (angle_cur[15:14] == 2'b01) || (angle_cur[15:14] == 2'b10);
    z32     = {angle_cur[15] ^ flip_in, angle_cur[14:0], 16'd0};
    dx      = y_r >>> cmd.iter;
    dy      = x_r >>> cmd.iter;
    atan_v  = $signed({2'b00, ATAN_TAB[cmd.iter]});
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= ROT_W'($signed(z32));
      flip_r <= flip_in;
    end else if (cmd.rot) begin
      if (!z_r[ROT_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_v;
      end
    end
  end

  // Cell multiplier: radius times cosine or sine, registered.
  logic signed [16:0]       mul_a;
  logic signed [ROT_W-1:0]  mul_b, trig;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, prod_rnd;
  logic signed [23:0]       off, cell_x_r, cell_y_r;

  always_comb begin
    trig     = cmd.sel_y ? y_r : x_r;
    mul_b    = flip_r ? -trig : trig;
    mul_a    = $signed({1'b0, r_cur_r[15:0]});
    prod_nxt = mul_a * mul_b;
    prod_rnd = prod_r + (PROD_W'(1) <<< 29);
    off      = prod_rnd[53:30];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_x) begin
      cell_x_r <= origin_x_r + off;
    end
    if (cmd.acc_y) begin
      cell_y_r <= origin_y_r + off;
    end
  end

  // Next free cell and end-of-sample decision.
  logic [16:0]   r_next;
  logic [NW-1:0] n_next;
  logic          more_free;
  logic          last_w;

  always_comb begin
    r_next    = r_cur_r + {1'b0, step_length_r};
    n_next    = n_r + 1'b1;
    more_free = ($signed({1'b0, r_next}) < limit_r) && (n_next < NW'(MAX_STEPS));
    last_w    = phase_occ_r || !(more_free || occ_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      range_r     <= range_s[15:0];
      limit_r     <= limit_full[17:0];
      occ_r       <= raw_occ;
      phase_occ_r <= !free0;
      r_cur_r     <= free0 ? 17'd0 : {1'b0, range_s[15:0]};
      n_r         <= '0;
    end else if (cmd.emit && !phase_occ_r) begin
      if (more_free) begin
        r_cur_r <= r_next;
        n_r     <= n_next;
      end else begin
        phase_occ_r <= 1'b1;
        r_cur_r     <= {1'b0, range_r};
      end
    end
  end

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  assign st = '{none: none_w, slot_free: !out_valid_r || !out_stall, last: last_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.is_occupied <= phase_occ_r;
      out_data_r.cell_x      <= cell_x_r;
      out_data_r.cell_y      <= cell_y_r;
      out_data_r.half_extent <= phase_occ_r ? 16'd0 : clear_radius_r;
      out_data_r.last        <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The free cell count never passes its limit.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> n_r < NW'(MAX_STEPS))
    else $error("free cell count overran");

  // An occupied cell is always the last of its sample and has no extent.
  a_occ_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && phase_occ_r) |-> st.last)
    else $error("occupied cell not last");

  // After the last cell of a sample, occupied or free, no further cell is issued straight after it.
  a_occ_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && st.last) |=> !cmd.emit)
    else $error("cell issued after the last one");

endmodule

// ----- rtl/lidar_scan_ray_cells.sv -----
// Lidar ray to occupancy cells: one range sample in, up to MAX_STEPS free
// cells along the beam plus, when the range lies below the maximum range, one
// occupied end cell out, each a transfer on the result channel with last
// marking the final cell of the sample. A sample that gives no cells is taken
// without leaving the idle state. Otherwise the block runs the CORDIC rotation
// and then, for each cell, the states MUL_X, ACC_X, MUL_Y, ACC_Y and EMIT on
// the single shared radius multiplier, EMIT waiting while the result side
// stalls. The next sample is taken once the last cell of the current one sits
// in the output register.
module lidar_scan_ray_cells #(
  parameter int MAX_STEPS  = 63,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lsrc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lsrc_pkg::cfg_idx_t  cfg_index,
  input  logic [23:0]         cfg_data
);
  import lsrc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  lsrc_ctrl #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lsrc_dp #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
